[rtl/core/sbc_pkg.sv]
// sbc_pkg: widths, constants and shared types of the swept box collision pipeline
// depends on nothing; every module of the block imports it
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

  localparam int FRAC_BITS = 16;
  // width of a 32 bit by 31 bit signed product
  localparam int P_W       = 63;
  // direction component after the fraction shift
  localparam int D_W       = P_W - FRAC_BITS;
  // slab numerators and mover centres
  localparam int N_W       = 34;
  localparam int C_W       = 33;
  // divider remainder, holds up to twice the divisor
  localparam int R_W       = D_W + 1;
  localparam int Q_STEPS   = FRAC_BITS + 1;
  // clamped slab time, signed
  localparam int T_W       = FRAC_BITS + 3;
  // split of the direction for the contact product
  localparam int LO_W      = D_W / 2;
  localparam int HI_W      = D_W - LO_W;
  localparam int PL_W      = FRAC_BITS + LO_W;
  localparam int PH_W      = FRAC_BITS + 1 + HI_W;
  localparam int OFF_W     = FRAC_BITS + D_W + 1;
  localparam int S_W       = D_W + 2;

  localparam logic signed [T_W-1:0] T_ONE = T_W'(1) <<< FRAC_BITS;
  localparam logic signed [T_W-1:0] T_SAT = T_W'(1) <<< (FRAC_BITS + 1);

  // division lanes
  localparam int LANE_NX = 0;
  localparam int LANE_FX = 1;
  localparam int LANE_NY = 2;
  localparam int LANE_FY = 3;

  typedef enum logic [2:0] {
    NORM_NONE  = 3'd0,
    NORM_POS_X = 3'd1,
    NORM_NEG_X = 3'd2,
    NORM_POS_Y = 3'd3,
    NORM_NEG_Y = 3'd4
  } normal_e;

  // sideband of one request while its divisions are in flight
  typedef struct packed {
    logic                  vzero;
    logic [1:0]            dzero;
    logic [1:0]            in_slab;
    logic [3:0]            neg;
    logic [3:0]            ovf;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
  } side_t;

endpackage
`default_nettype wire

[rtl/core/swept_box_collision.sv]
// swept_box_collision: top level, front stages, four slab dividers, back stages
// depends on sbc_pkg, sbc_front, sbc_div, sbc_back
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | request   | in_valid_i / in_stall_o  | mover, velocity, target, time step
//  out      | result    | out_valid_o / out_stall_i| hit, contact time, point, normal
//
// one request per cycle while the output is not stalled; each result passes through
// two front stages, one divider stage per quotient bit and three back stages
// reset clears the valid bits of every stage, no payload register is reset
// a stall on the output freezes the whole pipeline; the output register holds its
// result and the input is stalled in the same cycle, so nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none
module swept_box_collision (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] mover_x_i,
  input  logic signed [31:0] mover_y_i,
  input  logic        [30:0] mover_w_i,
  input  logic        [30:0] mover_h_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic        [30:0] target_w_i,
  input  logic        [30:0] target_h_i,
  input  logic        [30:0] time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic signed [31:0] contact_time_o,
  output logic signed [31:0] contact_x_o,
  output logic signed [31:0] contact_y_o,
  output logic [2:0]         normal_code_o
);
  import sbc_pkg::*;

  logic                    en;
  logic                    front_valid;
  side_t                   front_side;
  logic [3:0][R_W-1:0]     front_num;
  logic [3:0][D_W-1:0]     front_den;
  logic [3:0][Q_STEPS-1:0] quo;
  logic [Q_STEPS-1:0]      side_valid_q;
  side_t                   side_q [Q_STEPS];

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  sbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .mover_x_i   (mover_x_i),
    .mover_y_i   (mover_y_i),
    .mover_w_i   (mover_w_i),
    .mover_h_i   (mover_h_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .target_w_i  (target_w_i),
    .target_h_i  (target_h_i),
    .time_step_i (time_step_i),
    .valid_o     (front_valid),
    .side_o      (front_side),
    .num_o       (front_num),
    .den_o       (front_den)
  );

  for (genvar l = 0; l < 4; l++) begin : g_lane
    sbc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (front_num[l]),
      .den_i (front_den[l]),
      .quo_o (quo[l])
    );
  end

  // sideband rides alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_valid_q <= '0;
    end else if (en) begin
      side_valid_q <= {side_valid_q[Q_STEPS-2:0], front_valid};
    end
  end

  for (genvar k = 0; k < Q_STEPS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (k == 0) begin
          side_q[k].vzero   <= front_side.vzero;
          side_q[k].dzero   <= front_side.dzero;
          side_q[k].in_slab <= front_side.in_slab;
          side_q[k].neg     <= front_side.neg;
          side_q[k].ovf     <= front_side.ovf;
          side_q[k].dx      <= front_side.dx;
          side_q[k].dy      <= front_side.dy;
          side_q[k].cx      <= front_side.cx;
          side_q[k].cy      <= front_side.cy;
        end else begin
          side_q[k].vzero   <= side_q[(k == 0) ? 0 : k-1].vzero;
          side_q[k].dzero   <= side_q[(k == 0) ? 0 : k-1].dzero;
          side_q[k].in_slab <= side_q[(k == 0) ? 0 : k-1].in_slab;
          side_q[k].neg     <= side_q[(k == 0) ? 0 : k-1].neg;
          side_q[k].ovf     <= side_q[(k == 0) ? 0 : k-1].ovf;
          side_q[k].dx      <= side_q[(k == 0) ? 0 : k-1].dx;
          side_q[k].dy      <= side_q[(k == 0) ? 0 : k-1].dy;
          side_q[k].cx      <= side_q[(k == 0) ? 0 : k-1].cx;
          side_q[k].cy      <= side_q[(k == 0) ? 0 : k-1].cy;
        end
      end
    end
  end

  sbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (side_valid_q[Q_STEPS-1]),
    .side_i         (side_q[Q_STEPS-1]),
    .quo_i          (quo),
    .out_valid_o    (out_valid_o),
    .hit_o          (hit_o),
    .contact_time_o (contact_time_o),
    .contact_x_o    (contact_x_o),
    .contact_y_o    (contact_y_o),
    .normal_code_o  (normal_code_o)
  );

endmodule
`default_nettype wire

[rtl/core/sbc_front.sv]
// sbc_front: direction products, slab numerators and divider operands, two stages
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [31:0]                  mover_x_i,
  input  logic signed [31:0]                  mover_y_i,
  input  logic        [30:0]                  mover_w_i,
  input  logic        [30:0]                  mover_h_i,
  input  logic signed [31:0]                  vel_x_i,
  input  logic signed [31:0]                  vel_y_i,
  input  logic signed [31:0]                  target_x_i,
  input  logic signed [31:0]                  target_y_i,
  input  logic        [30:0]                  target_w_i,
  input  logic        [30:0]                  target_h_i,
  input  logic        [30:0]                  time_step_i,
  output logic                                valid_o,
  output sbc_pkg::side_t                      side_o,
  output logic [3:0][sbc_pkg::R_W-1:0]        num_o,
  output logic [3:0][sbc_pkg::D_W-1:0]        den_o
);
  import sbc_pkg::*;

  logic signed [63:0]    prod_x, prod_y;
  logic                  a_valid_q, a_vzero_q;
  logic signed [D_W-1:0] a_dx_q, a_dy_q;
  logic signed [N_W-1:0] a_nnx_q, a_fnx_q, a_nny_q, a_fny_q;
  logic signed [C_W-1:0] a_cx_q, a_cy_q;

  logic                  valid_q;
  side_t                 side_d, side_q;
  logic [3:0][R_W-1:0]   num_d, num_q;
  logic [3:0][D_W-1:0]   den_d, den_q;
  logic signed [N_W-1:0] lane_num [4];
  logic signed [D_W-1:0] lane_d [4];
  logic [N_W-1:0]        mag_n [4];
  logic [D_W-1:0]        mag_d [4];

  assign prod_x = 64'(vel_x_i) * 64'($signed({1'b0, time_step_i}));
  assign prod_y = 64'(vel_y_i) * 64'($signed({1'b0, time_step_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_vzero_q <= (vel_x_i == 32'sd0) && (vel_y_i == 32'sd0);
      // arithmetic shift of the product is the floor
      a_dx_q    <= prod_x[P_W-1:FRAC_BITS];
      a_dy_q    <= prod_y[P_W-1:FRAC_BITS];
      a_nnx_q   <= N_W'(target_x_i) - N_W'(mover_x_i) - N_W'(mover_w_i);
      a_fnx_q   <= N_W'(target_x_i) + N_W'(target_w_i) - N_W'(mover_x_i);
      a_nny_q   <= N_W'(target_y_i) - N_W'(mover_y_i) - N_W'(mover_h_i);
      a_fny_q   <= N_W'(target_y_i) + N_W'(target_h_i) - N_W'(mover_y_i);
      a_cx_q    <= C_W'(mover_x_i) + C_W'(mover_w_i[30:1]);
      a_cy_q    <= C_W'(mover_y_i) + C_W'(mover_h_i[30:1]);
    end
  end

  always_comb begin
    lane_num[LANE_NX] = a_nnx_q;
    lane_num[LANE_FX] = a_fnx_q;
    lane_num[LANE_NY] = a_nny_q;
    lane_num[LANE_FY] = a_fny_q;
    lane_d[LANE_NX]   = a_dx_q;
    lane_d[LANE_FX]   = a_dx_q;
    lane_d[LANE_NY]   = a_dy_q;
    lane_d[LANE_FY]   = a_dy_q;
    side_d         = '0;
    side_d.vzero   = a_vzero_q;
    side_d.dzero   = {a_dy_q == '0, a_dx_q == '0};
    side_d.in_slab = {(a_nny_q <= 0) && (a_fny_q >= 0), (a_nnx_q <= 0) && (a_fnx_q >= 0)};
    side_d.dx      = a_dx_q;
    side_d.dy      = a_dy_q;
    side_d.cx      = a_cx_q;
    side_d.cy      = a_cy_q;
    for (int l = 0; l < 4; l++) begin
      mag_n[l] = lane_num[l][N_W-1] ? N_W'(-lane_num[l]) : N_W'(lane_num[l]);
      mag_d[l] = lane_d[l][D_W-1] ? D_W'(-lane_d[l]) : D_W'(lane_d[l]);
      side_d.neg[l] = lane_num[l][N_W-1] ^ lane_d[l][D_W-1];
      // quotient at least twice one: clamp, its order is all that matters
      side_d.ovf[l] = R_W'(mag_n[l]) >= {mag_d[l], 1'b0};
      num_d[l] = side_d.ovf[l] ? '0 : R_W'(mag_n[l]);
      den_d[l] = mag_d[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q.vzero   <= side_d.vzero;
      side_q.dzero   <= side_d.dzero;
      side_q.in_slab <= side_d.in_slab;
      side_q.neg     <= side_d.neg;
      side_q.ovf     <= side_d.ovf;
      side_q.dx      <= side_d.dx;
      side_q.dy      <= side_d.dy;
      side_q.cx      <= side_d.cx;
      side_q.cy      <= side_d.cy;
      num_q          <= num_d;
      den_q          <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule
`default_nettype wire

[rtl/core/sbc_div.sv]
// sbc_div: pipelined restoring divider, one quotient bit per stage
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbc_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sbc_pkg::R_W-1:0]       num_i,
  input  logic [sbc_pkg::D_W-1:0]       den_i,
  output logic [sbc_pkg::Q_STEPS-1:0]   quo_o
);
  import sbc_pkg::*;

  logic [R_W-1:0]     rem_q [Q_STEPS];
  logic [D_W-1:0]     den_q [Q_STEPS];
  logic [Q_STEPS-1:0] quo_q [Q_STEPS];

  for (genvar k = 0; k < Q_STEPS; k++) begin : g_step
    logic [R_W-1:0]     r_in, t;
    logic [D_W-1:0]     d_in;
    logic [Q_STEPS-1:0] q_in;
    logic               ge;

    if (k == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
    end

    // remainder stays below twice the divisor at every step
    assign ge = r_in >= R_W'(d_in);
    assign t  = ge ? (r_in - R_W'(d_in)) : r_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= {t[R_W-2:0], 1'b0};
        den_q[k] <= d_in;
        quo_q[k] <= {q_in[Q_STEPS-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[Q_STEPS-1];

endmodule
`default_nettype wire

[rtl/core/sbc_back.sv]
// sbc_back: slab intervals, hit decision, contact point and the output register
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  sbc_pkg::side_t                    side_i,
  input  logic [3:0][sbc_pkg::Q_STEPS-1:0]  quo_i,
  output logic                              out_valid_o,
  output logic                              hit_o,
  output logic signed [31:0]                contact_time_o,
  output logic signed [31:0]                contact_x_o,
  output logic signed [31:0]                contact_y_o,
  output logic [2:0]                        normal_code_o
);
  import sbc_pkg::*;

  // interval stage
  logic signed [T_W-1:0] q [4];
  logic signed [T_W-1:0] nx_d, fx_d, ny_d, fy_d;
  logic signed [T_W-1:0] c_nx_q, c_fx_q, c_ny_q, c_fy_q;
  logic                  c_valid_q, c_miss_q;
  logic signed [D_W-1:0] c_dx_q, c_dy_q;
  logic signed [C_W-1:0] c_cx_q, c_cy_q;

  // decision stage
  logic signed [T_W-1:0] tnear, tfar;
  logic                  hit_d;
  normal_e               norm_d;
  logic [FRAC_BITS-1:0]  tn;
  logic                  e_valid_q, e_hit_q;
  normal_e               e_norm_q;
  logic [FRAC_BITS-1:0]  e_tn_q;
  logic [PL_W-1:0]       e_plx_q, e_ply_q;
  logic signed [PH_W-1:0] e_phx_q, e_phy_q;
  logic signed [C_W-1:0] e_cx_q, e_cy_q;

  // contact stage
  logic signed [OFF_W-1:0] offx, offy;
  logic signed [S_W-1:0]   sumx, sumy;
  logic signed [31:0]      satx, saty;
  logic                    out_valid_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q[l] = side_i.ovf[l] ? T_SAT : T_W'(quo_i[l]);
      if (side_i.neg[l]) begin
        q[l] = -q[l];
      end
    end
    if (side_i.dzero[0]) begin
      nx_d = -T_SAT;
      fx_d = T_SAT;
    end else begin
      nx_d = (q[LANE_NX] > q[LANE_FX]) ? q[LANE_FX] : q[LANE_NX];
      fx_d = (q[LANE_NX] > q[LANE_FX]) ? q[LANE_NX] : q[LANE_FX];
    end
    if (side_i.dzero[1]) begin
      ny_d = -T_SAT;
      fy_d = T_SAT;
    end else begin
      ny_d = (q[LANE_NY] > q[LANE_FY]) ? q[LANE_FY] : q[LANE_NY];
      fy_d = (q[LANE_NY] > q[LANE_FY]) ? q[LANE_NY] : q[LANE_FY];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q   <= valid_i;
      e_valid_q   <= c_valid_q;
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_nx_q   <= nx_d;
      c_fx_q   <= fx_d;
      c_ny_q   <= ny_d;
      c_fy_q   <= fy_d;
      // a still axis outside its grown slab never meets the target
      c_miss_q <= side_i.vzero || (side_i.dzero[0] && !side_i.in_slab[0])
                  || (side_i.dzero[1] && !side_i.in_slab[1]);
      c_dx_q   <= side_i.dx;
      c_dy_q   <= side_i.dy;
      c_cx_q   <= side_i.cx;
      c_cy_q   <= side_i.cy;
    end
  end

  always_comb begin
    tnear = (c_nx_q > c_ny_q) ? c_nx_q : c_ny_q;
    tfar  = (c_fx_q < c_fy_q) ? c_fx_q : c_fy_q;
    hit_d = !c_miss_q && !(c_nx_q > c_fy_q) && !(c_ny_q > c_fx_q)
            && (tfar >= 0) && (tnear >= 0) && (tnear < T_ONE);
    tn    = tnear[FRAC_BITS-1:0];
    priority if (c_nx_q > c_ny_q) begin
      norm_d = c_dx_q[D_W-1] ? NORM_POS_X : NORM_NEG_X;
    end else if (c_nx_q < c_ny_q) begin
      norm_d = c_dy_q[D_W-1] ? NORM_POS_Y : NORM_NEG_Y;
    end else begin
      norm_d = NORM_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_hit_q  <= hit_d;
      e_norm_q <= norm_d;
      e_tn_q   <= tn;
      // direction split in two so each product stays narrow
      e_plx_q  <= PL_W'(tn) * PL_W'(c_dx_q[LO_W-1:0]);
      e_ply_q  <= PL_W'(tn) * PL_W'(c_dy_q[LO_W-1:0]);
      e_phx_q  <= PH_W'($signed({1'b0, tn})) * PH_W'($signed(c_dx_q[D_W-1:LO_W]));
      e_phy_q  <= PH_W'($signed({1'b0, tn})) * PH_W'($signed(c_dy_q[D_W-1:LO_W]));
      e_cx_q   <= c_cx_q;
      e_cy_q   <= c_cy_q;
    end
  end

  always_comb begin
    offx = (OFF_W'(e_phx_q) <<< LO_W) + OFF_W'(e_plx_q);
    offy = (OFF_W'(e_phy_q) <<< LO_W) + OFF_W'(e_ply_q);
    sumx = S_W'(e_cx_q) + S_W'($signed(offx[OFF_W-1:FRAC_BITS]));
    sumy = S_W'(e_cy_q) + S_W'($signed(offy[OFF_W-1:FRAC_BITS]));
    priority if (sumx > S_W'(32'sh7fffffff)) begin
      satx = 32'sh7fffffff;
    end else if (sumx < S_W'(-33'sh80000000)) begin
      satx = -32'sh80000000;
    end else begin
      satx = sumx[31:0];
    end
    priority if (sumy > S_W'(32'sh7fffffff)) begin
      saty = 32'sh7fffffff;
    end else if (sumy < S_W'(-33'sh80000000)) begin
      saty = -32'sh80000000;
    end else begin
      saty = sumy[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o          <= e_hit_q;
      contact_time_o <= e_hit_q ? 32'(e_tn_q) : '0;
      contact_x_o    <= e_hit_q ? satx : '0;
      contact_y_o    <= e_hit_q ? saty : '0;
      normal_code_o  <= e_hit_q ? e_norm_q : NORM_NONE;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[test/testbench.sv]
// testbench: self-checking bench for the swept box collision pipeline
// depends on sbc_pkg and swept_box_collision; predicts each result from the request
`timescale 1ns / 1ps
module testbench;
  import sbc_pkg::*;

  typedef struct {
    logic signed [31:0] mover_x, mover_y;
    logic        [30:0] mover_w, mover_h;
    logic signed [31:0] vel_x, vel_y;
    logic signed [31:0] target_x, target_y;
    logic        [30:0] target_w, target_h;
    logic        [30:0] time_step;
  } box_pair_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] contact_time;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    normal_e            normal;
  } contact_t;

  localparam longint ONE     = 64'sd1 << FRAC_BITS;
  localparam longint SLAB_INF = 64'sd1 << 62;
  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     DRAIN_CYCLES   = FRAC_BITS + 16;

  class contact_board;
    contact_t pending[$];
    int       errors;

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // slab interval of one axis, zero direction means an unbounded interval or no hit
    static function bit slab(longint nnum, longint fnum, longint d,
                             output longint tn, output longint tf);
      longint a;
      longint b;
      tn = 0;
      tf = 0;
      if (d == 0) begin
        if (nnum <= 0 && fnum >= 0) begin
          tn = -SLAB_INF;
          tf = SLAB_INF;
          return 1;
        end
        return 0;
      end
      a = (nnum * ONE) / d;
      b = (fnum * ONE) / d;
      tn = (a > b) ? b : a;
      tf = (a > b) ? a : b;
      return 1;
    endfunction

    static function contact_t sweep(box_pair_t p);
      contact_t r;
      longint mx, my, mw, mh, vx, vy, tx, ty, tw, th, dt;
      longint dx, dy, nxa, fxa, nya, fya, tnear, tfar;
      r = '{0, 0, 0, 0, NORM_NONE};
      mx = p.mover_x;  my = p.mover_y;
      mw = longint'({1'b0, p.mover_w});  mh = longint'({1'b0, p.mover_h});
      vx = p.vel_x;  vy = p.vel_y;
      tx = p.target_x;  ty = p.target_y;
      tw = longint'({1'b0, p.target_w});  th = longint'({1'b0, p.target_h});
      dt = longint'({1'b0, p.time_step});
      if (vx == 0 && vy == 0) return r;
      dx = (vx * dt) >>> FRAC_BITS;
      dy = (vy * dt) >>> FRAC_BITS;
      if (!slab(tx - mx - mw, tx + tw - mx, dx, nxa, fxa)) return r;
      if (!slab(ty - my - mh, ty + th - my, dy, nya, fya)) return r;
      if (nxa > fya || nya > fxa) return r;
      tnear = (nxa > nya) ? nxa : nya;
      tfar  = (fxa < fya) ? fxa : fya;
      if (tfar < 0 || tnear < 0 || tnear >= ONE) return r;
      r.hit = 1;
      r.contact_time = tnear[31:0];
      r.contact_x = 32'(sat32(mx + (mw >>> 1) + ((tnear * dx) >>> FRAC_BITS)));
      r.contact_y = 32'(sat32(my + (mh >>> 1) + ((tnear * dy) >>> FRAC_BITS)));
      if (nxa > nya) r.normal = (dx < 0) ? NORM_POS_X : NORM_NEG_X;
      else if (nxa < nya) r.normal = (dy < 0) ? NORM_POS_Y : NORM_NEG_Y;
      return r;
    endfunction

    function void note_request(box_pair_t p);
      pending.push_back(sweep(p));
    endfunction

    function void check_result(contact_t got);
      contact_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b", $time, got.hit);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b got %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.contact_time !== want.contact_time) begin
        $display("%0t: contact_time expected %h got %h", $time, want.contact_time,
                 got.contact_time);
        errors++;
      end
      if (got.contact_x !== want.contact_x) begin
        $display("%0t: contact_x expected %h got %h", $time, want.contact_x, got.contact_x);
        errors++;
      end
      if (got.contact_y !== want.contact_y) begin
        $display("%0t: contact_y expected %h got %h", $time, want.contact_y, got.contact_y);
        errors++;
      end
      if (got.normal !== want.normal) begin
        $display("%0t: normal expected %0d got %0d", $time, want.normal, got.normal);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic signed [31:0] mover_x_i = 0, mover_y_i = 0;
  logic        [30:0] mover_w_i = 0, mover_h_i = 0;
  logic signed [31:0] vel_x_i = 0, vel_y_i = 0;
  logic signed [31:0] target_x_i = 0, target_y_i = 0;
  logic        [30:0] target_w_i = 0, target_h_i = 0;
  logic        [30:0] time_step_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic               hit_o;
  logic signed [31:0] contact_time_o, contact_x_o, contact_y_o;
  logic [2:0]         normal_code_o;

  contact_board board = new();
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_cycles = 0;
  int  handshakes = 0;
  bit  stim_done = 0;

  swept_box_collision u_top (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // result side: stall at random or for a long hold, check every accepted result
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result('{hit_o, contact_time_o, contact_x_o, contact_y_o,
                           normal_e'(normal_code_o)});
      handshakes++;
    end
  end

  task automatic send_request(box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 0;
    end
    @(negedge clk_i);
    in_valid_i  = 1;
    mover_x_i   = p.mover_x;   mover_y_i  = p.mover_y;
    mover_w_i   = p.mover_w;   mover_h_i  = p.mover_h;
    vel_x_i     = p.vel_x;     vel_y_i    = p.vel_y;
    target_x_i  = p.target_x;  target_y_i = p.target_y;
    target_w_i  = p.target_w;  target_h_i = p.target_h;
    time_step_i = p.time_step;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(p);
    handshakes++;
  endtask

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(1 << 23)) - (1 << 22);
  endfunction

  // a mover aimed roughly at the target, so most of these reach the slab logic
  function automatic box_pair_t aimed_pair();
    box_pair_t p;
    int kind;
    p.target_x = near_coord();
    p.target_y = near_coord();
    p.target_w = 31'($urandom_range(1 << 20));
    p.target_h = 31'($urandom_range(1 << 20));
    p.mover_w  = 31'($urandom_range(1 << 20));
    p.mover_h  = 31'($urandom_range(1 << 20));
    p.mover_x  = p.target_x + near_coord();
    p.mover_y  = p.target_y + near_coord();
    p.time_step = 31'($urandom_range(1 << 18, 1 << 14));
    p.vel_x = (p.target_x - p.mover_x) + $signed($urandom_range(1 << 20)) - (1 << 19);
    p.vel_y = (p.target_y - p.mover_y) + $signed($urandom_range(1 << 20)) - (1 << 19);
    kind = $urandom_range(9);
    if (kind == 0) p.vel_x = 0;
    if (kind == 1) p.vel_y = 0;
    if (kind == 2) begin
      // symmetric geometry gives equal entry times on both axes
      p.mover_h = p.mover_w;  p.target_h = p.target_w;
      p.mover_y = p.target_y + (p.mover_x - p.target_x);
      p.vel_y = p.vel_x;
    end
    return p;
  endfunction

  function automatic box_pair_t noise_pair();
    box_pair_t p;
    p.mover_x = $urandom;        p.mover_y = $urandom;
    p.mover_w = 31'($urandom);   p.mover_h = 31'($urandom);
    p.vel_x = $urandom;          p.vel_y = $urandom;
    p.target_x = $urandom;       p.target_y = $urandom;
    p.target_w = 31'($urandom);  p.target_h = 31'($urandom);
    p.time_step = 31'($urandom);
    return p;
  endfunction

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_request(($urandom_range(4) == 0) ? noise_pair() : aimed_pair());
  endtask

  initial begin
    box_pair_t p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: head-on hits on each axis, ties, zero velocity, grazing and extremes
    p = '{0, 0, 31'h10000, 31'h10000, 32'sh40000, 0, 32'sh50000, 0,
          31'h10000, 31'h10000, 31'h10000};
    send_request(p);
    p.vel_x = -32'sh40000;  p.target_x = -32'sh50000;
    send_request(p);
    p = '{0, 0, 31'h10000, 31'h10000, 0, 32'sh40000, 0, 32'sh50000,
          31'h10000, 31'h10000, 31'h10000};
    send_request(p);
    p.vel_y = -32'sh40000;  p.target_y = -32'sh50000;
    send_request(p);
    // diagonal tie
    p = '{0, 0, 31'h10000, 31'h10000, 32'sh40000, 32'sh40000, 32'sh30000, 32'sh30000,
          31'h10000, 31'h10000, 31'h10000};
    send_request(p);
    p.vel_x = 0;  p.vel_y = 0;
    send_request(p);
    // zero x direction, inside and outside the grown slab
    p = '{0, 0, 31'h10000, 31'h10000, 0, 32'sh40000, 0, 32'sh30000,
          31'h10000, 31'h10000, 31'h10000};
    send_request(p);
    p.target_x = 32'sh80000;
    send_request(p);
    // already overlapping, touching at the far edge
    p = '{0, 0, 31'h20000, 31'h20000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
          31'h10000, 31'h10000, 31'h10000};
    send_request(p);
    p = '{0, 0, 31'h10000, 31'h10000, 32'sh10000, 0, 32'sh20000, 0,
          31'h10000, 31'h10000, 31'h10000};
    send_request(p);
    // zero time step
    p.time_step = 0;
    send_request(p);
    // extremes of every field
    p = '{32'h80000000, 32'h80000000, '1, '1, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff, '1, '1, '1};
    send_request(p);
    p = '{32'h7fffffff, 32'h7fffffff, 0, 0, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h80000000, 0, 0, '1};
    send_request(p);
    p = '{32'h80000000, 32'h80000000, '1, '1, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h80000000, '1, 0, 31'h10000};
    send_request(p);
    p = '{0, 0, 0, 0, 1, -1, 0, 0, 0, 0, 31'h10000};
    send_request(p);

    run_phase(0, 0, 150);
    hold_cycles = 300;
    run_phase(46, 0, 150);
    run_phase(0, 46, 150);
    run_phase(11, 11, 150);
    @(negedge clk_i);
    in_valid_i = 0;
    stim_done = 1;
  end

  initial begin
    int idle;
    int last;
    idle = 0;
    last = 0;
    while (idle < WATCHDOG_LIMIT && !(stim_done && board.pending.size() == 0)) begin
      @(posedge clk_i);
      #0;
      if (handshakes != last) idle = 0;
      else idle++;
      last = handshakes;
    end
    if (idle < WATCHDOG_LIMIT) begin
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
    if (idle < WATCHDOG_LIMIT && board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[swept_box_collision.f]
rtl/core/sbc_pkg.sv
rtl/core/sbc_front.sv
rtl/core/sbc_div.sv
rtl/core/sbc_back.sv
rtl/core/swept_box_collision.sv
test/testbench.sv
